@@ rtl/qtba_pkg.sv @@
package qtba_pkg;

    localparam int ATLAS_SIZE_LOG2_DEF = 12;
    localparam int LEAF_SIZE_LOG2_DEF  = 8;
    localparam int TREE_NODES_DEF      = 341;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ND_FREE  = 2'd0;
    localparam logic [1:0] ND_SPLIT = 2'd1;
    localparam logic [1:0] ND_OCC   = 2'd2;

    localparam logic CFG_PADDING = 1'b0;
    localparam logic CFG_MAX_RES = 1'b1;

    localparam logic [7:0]  PAD_RESET    = 8'd2;
    localparam logic [12:0] MAXRES_RESET = 13'd4096;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_DEC,
        ST_S_RD,
        ST_S_EV,
        ST_S_CHK,
        ST_S_RET,
        ST_M_RD,
        ST_M_EV,
        ST_M_CRD,
        ST_M_CEV,
        ST_M_DONE,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic clr_start;
        logic clr_step;
        logic root;
        logic rd_node;
        logic rd_m;
        logic rd_c;
        logic wr_occ;
        logic descend;
        logic sib;
        logic ascend;
        logic free_wr;
        logic m_start;
        logic m_next;
        logic m_wr;
        logic res_fail;
        logic res_ok;
        logic res_grant;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] node_st;
        logic       rej;
        logic       rel_bad;
        logic       rel_root;
        logic       at_target;
        logic       at_leaf;
        logic       node_oob;
        logic       node_root;
        logic       k_last;
        logic       m_child_oob;
        logic       cidx_last;
        logic       m_root;
        logic       clr_last;
    } t_status;

    // log2 of the size rounded up to a power of two, clamped to 256..4096
    function automatic logic [3:0] round_log2(input logic [15:0] r);
        logic [3:0] l;
        if (r <= 16'd256)       l = 4'd8;
        else if (r <= 16'd512)  l = 4'd9;
        else if (r <= 16'd1024) l = 4'd10;
        else if (r <= 16'd2048) l = 4'd11;
        else                    l = 4'd12;
        return l;
    endfunction

endpackage

@@ rtl/qtba_ctrl.sv @@
module qtba_ctrl
    import qtba_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    output logic    o_rsp_valid,
    input  logic    i_rsp_ready,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_mret, r_clr_resp;
    logic   set_mret, clr_mret, set_clr_resp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLR;
            r_mret     <= 1'b0;
            r_clr_resp <= 1'b0;
        end else begin
            r_state <= n_state;
            if (set_mret) r_mret <= 1'b1;
            else if (clr_mret) r_mret <= 1'b0;
            if (set_clr_resp) r_clr_resp <= 1'b1;
            else if (r_state == ST_IDLE) r_clr_resp <= 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLR:  if (i_st.clr_last) n_state = r_clr_resp ? ST_RESP : ST_IDLE;
            ST_IDLE: if (i_req_valid) n_state = ST_DEC;
            ST_DEC: begin
                priority case (i_st.op)
                    OP_ALLOC: n_state = i_st.rej ? ST_RESP : ST_S_RD;
                    OP_FREE:  n_state = (i_st.rel_bad || i_st.rel_root) ? ST_RESP : ST_M_RD;
                    OP_CLEAR: n_state = ST_CLR;
                    default:  n_state = ST_RESP;
                endcase
            end
            ST_S_RD: n_state = ST_S_EV;
            ST_S_EV: begin
                if (i_st.node_st == ND_OCC) n_state = ST_S_RET;
                else if (i_st.at_target)
                    n_state = (i_st.node_st == ND_SPLIT) ? ST_S_RET : ST_RESP;
                else if (i_st.at_leaf) n_state = ST_S_RET;
                else if (i_st.node_st == ND_FREE || i_st.node_st == ND_SPLIT)
                    n_state = ST_S_CHK;
                else n_state = ST_S_RET;
            end
            ST_S_CHK: n_state = i_st.node_oob ? ST_S_RET : ST_S_RD;
            ST_S_RET: begin
                if (i_st.node_root) n_state = ST_RESP;
                else if (i_st.k_last) n_state = ST_M_RD;
                else n_state = ST_S_CHK;
            end
            ST_M_RD: n_state = ST_M_EV;
            ST_M_EV: n_state = (i_st.node_st == ND_SPLIT) ? ST_M_CRD : ST_M_DONE;
            ST_M_CRD: n_state = i_st.m_child_oob ? ST_M_DONE : ST_M_CEV;
            ST_M_CEV: begin
                if (i_st.node_st != ND_FREE) n_state = ST_M_DONE;
                else if (!i_st.cidx_last) n_state = ST_M_CRD;
                else n_state = i_st.m_root ? ST_M_DONE : ST_M_RD;
            end
            ST_M_DONE: n_state = r_mret ? ST_S_RET : ST_RESP;
            ST_RESP: if (i_rsp_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        set_mret     = 1'b0;
        clr_mret     = 1'b0;
        set_clr_resp = 1'b0;
        o_req_ready  = (r_state == ST_IDLE);
        o_rsp_valid  = (r_state == ST_RESP);
        unique case (r_state)
            ST_CLR:  o_cmd.clr_step = 1'b1;
            ST_IDLE: o_cmd.load = i_req_valid;
            ST_DEC: begin
                priority case (i_st.op)
                    OP_ALLOC: begin
                        if (i_st.rej) o_cmd.res_fail = 1'b1;
                        else o_cmd.root = 1'b1;
                    end
                    OP_FREE: begin
                        if (i_st.rel_bad) o_cmd.res_fail = 1'b1;
                        else begin
                            o_cmd.free_wr = 1'b1;
                            clr_mret      = 1'b1;
                            if (i_st.rel_root) o_cmd.res_ok = 1'b1;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.res_ok    = 1'b1;
                        o_cmd.clr_start = 1'b1;
                        set_clr_resp    = 1'b1;
                    end
                    default: o_cmd.res_fail = 1'b1;
                endcase
            end
            ST_S_RD: o_cmd.rd_node = 1'b1;
            ST_S_EV: begin
                if (i_st.node_st == ND_OCC) begin
                end else if (i_st.at_target) begin
                    if (i_st.node_st != ND_SPLIT) begin
                        o_cmd.wr_occ    = 1'b1;
                        o_cmd.res_grant = 1'b1;
                    end
                end else if (!i_st.at_leaf &&
                             (i_st.node_st == ND_FREE || i_st.node_st == ND_SPLIT)) begin
                    o_cmd.descend = 1'b1;
                end
            end
            ST_S_CHK: begin
            end
            ST_S_RET: begin
                if (i_st.node_root) o_cmd.res_fail = 1'b1;
                else if (i_st.k_last) begin
                    o_cmd.ascend = 1'b1;
                    set_mret     = 1'b1;
                end else o_cmd.sib = 1'b1;
            end
            ST_M_RD: o_cmd.rd_m = 1'b1;
            ST_M_EV: if (i_st.node_st == ND_SPLIT) o_cmd.m_start = 1'b1;
            ST_M_CRD: if (!i_st.m_child_oob) o_cmd.rd_c = 1'b1;
            ST_M_CEV: begin
                if (i_st.node_st == ND_FREE) begin
                    if (i_st.cidx_last) o_cmd.m_wr = 1'b1;
                    else o_cmd.m_next = 1'b1;
                end
            end
            ST_M_DONE: if (!r_mret) o_cmd.res_ok = 1'b1;
            ST_RESP: begin
            end
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/qtba_dp.sv @@
module qtba_dp
    import qtba_pkg::*;
#(
    parameter int ATLAS_SIZE_LOG2 = ATLAS_SIZE_LOG2_DEF,
    parameter int LEAF_SIZE_LOG2  = LEAF_SIZE_LOG2_DEF,
    parameter int TREE_NODES      = TREE_NODES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_wdata,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_requested_resolution,
    input  logic        i_release_valid,
    input  logic [8:0]  i_release_node,
    input  t_cmd        i_cmd,
    output t_status     o_st,
    output logic        o_done_ok,
    output logic [8:0]  o_granted_node,
    output logic [11:0] o_block_x,
    output logic [11:0] o_block_y,
    output logic [12:0] o_block_size,
    output logic [11:0] o_view_x,
    output logic [11:0] o_view_y,
    output logic [12:0] o_view_size
);

    localparam int NW  = $clog2(TREE_NODES);
    localparam int NXW = NW + 3;
    localparam int LW  = $clog2(ATLAS_SIZE_LOG2 + 1);
    localparam int CW  = ATLAS_SIZE_LOG2;
    localparam int SW  = ATLAS_SIZE_LOG2 + 1;

    logic [1:0]     r_mem [TREE_NODES];
    logic [1:0]     r_rdata;
    logic [7:0]     r_pad;
    logic [12:0]    r_maxres;
    logic [1:0]     r_op;
    logic [3:0]     r_tl;
    logic           r_rv;
    logic [8:0]     r_rn;
    logic [NXW-1:0] r_node;
    logic [LW-1:0]  r_lvl;
    logic [CW-1:0]  r_x, r_y;
    logic [NW-1:0]  r_m;
    logic [1:0]     r_cidx;
    logic [NW-1:0]  r_clr;

    logic [NXW-1:0] nm1, mchild;
    logic [1:0]     kn;
    logic [CW-1:0]  bmask;
    logic [NW-1:0]  raddr, waddr;
    logic [1:0]     wdata;
    logic           we, rd;
    logic [SW-1:0]  size, half, inset, vsize;
    logic [SW:0]    twice;

    assign nm1    = r_node - NXW'(1);
    assign kn     = nm1[1:0] + 2'd1;
    assign bmask  = CW'(1) << r_lvl;
    assign mchild = (NXW'(r_m) << 2) + NXW'(1) + NXW'(r_cidx);

    // viewport of the block at the current node
    assign size  = SW'(1) << r_lvl;
    assign half  = size >> 1;
    assign inset = (SW'(r_pad) < half) ? SW'(r_pad) : half;
    assign twice = {inset, 1'b0};
    assign vsize = ((SW + 1)'(size) > twice) ? SW'((SW + 1)'(size) - twice) : size;

    always_comb begin
        o_st             = '0;
        o_st.op          = r_op;
        o_st.node_st     = r_rdata;
        o_st.rej         = (r_tl < 4'(LEAF_SIZE_LOG2)) || (32'(r_tl) > 32'(ATLAS_SIZE_LOG2))
                           || ((32'd1 << r_tl) > 32'(r_maxres));
        o_st.rel_bad     = !r_rv || (32'(r_rn) >= 32'(TREE_NODES));
        o_st.rel_root    = (r_rn == 9'd0);
        o_st.at_target   = (32'(r_lvl) == 32'(r_tl));
        o_st.at_leaf     = (32'(r_lvl) <= 32'(LEAF_SIZE_LOG2));
        o_st.node_oob    = (32'(r_node) >= 32'(TREE_NODES));
        o_st.node_root   = (r_node == '0);
        o_st.k_last      = (nm1[1:0] == 2'd3);
        o_st.m_child_oob = (32'(mchild) >= 32'(TREE_NODES));
        o_st.cidx_last   = (r_cidx == 2'd3);
        o_st.m_root      = (r_m == '0);
        o_st.clr_last    = (32'(r_clr) == 32'(TREE_NODES - 1));
    end

    // single-port style access to the node state memory
    always_comb begin
        rd    = i_cmd.rd_node | i_cmd.rd_m | i_cmd.rd_c;
        raddr = r_node[NW-1:0];
        if (i_cmd.rd_m) raddr = r_m;
        else if (i_cmd.rd_c) raddr = mchild[NW-1:0];
        we    = 1'b1;
        waddr = r_node[NW-1:0];
        wdata = ND_FREE;
        priority if (i_cmd.clr_step) begin
            waddr = r_clr;
        end else if (i_cmd.wr_occ) begin
            wdata = ND_OCC;
        end else if (i_cmd.descend) begin
            wdata = ND_SPLIT;
        end else if (i_cmd.free_wr) begin
            waddr = NW'(r_rn);
        end else if (i_cmd.m_wr) begin
            waddr = r_m;
        end else begin
            we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        if (rd) r_rdata <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad    <= PAD_RESET;
            r_maxres <= MAXRES_RESET;
            r_clr    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PADDING: r_pad    <= i_cfg_wdata[7:0];
                    CFG_MAX_RES: r_maxres <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.clr_start) r_clr <= '0;
            else if (i_cmd.clr_step) r_clr <= r_clr + NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_opcode;
            r_tl <= round_log2(i_requested_resolution);
            r_rv <= i_release_valid;
            r_rn <= i_release_node;
        end
        if (i_cmd.root) begin
            r_node <= '0;
            r_lvl  <= LW'(ATLAS_SIZE_LOG2);
            r_x    <= '0;
            r_y    <= '0;
        end else if (i_cmd.descend) begin
            r_node <= (r_node << 2) + NXW'(1);
            r_lvl  <= r_lvl - LW'(1);
        end else if (i_cmd.sib) begin
            r_node <= r_node + NXW'(1);
            r_x    <= kn[0] ? (r_x | bmask) : (r_x & ~bmask);
            r_y    <= kn[1] ? (r_y | bmask) : (r_y & ~bmask);
        end else if (i_cmd.ascend) begin
            r_node <= nm1 >> 2;
            r_lvl  <= r_lvl + LW'(1);
            r_x    <= r_x & ~bmask;
            r_y    <= r_y & ~bmask;
        end
        if (i_cmd.ascend) r_m <= NW'(nm1 >> 2);
        else if (i_cmd.free_wr) r_m <= NW'((r_rn - 9'd1) >> 2);
        else if (i_cmd.m_wr) r_m <= NW'((NXW'(r_m) - NXW'(1)) >> 2);
        if (i_cmd.m_start) r_cidx <= 2'd0;
        else if (i_cmd.m_next) r_cidx <= r_cidx + 2'd1;

        if (i_cmd.res_fail || i_cmd.res_ok) begin
            o_done_ok      <= i_cmd.res_ok;
            o_granted_node <= '0;
            o_block_x      <= '0;
            o_block_y      <= '0;
            o_block_size   <= '0;
            o_view_x       <= '0;
            o_view_y       <= '0;
            o_view_size    <= '0;
        end else if (i_cmd.res_grant) begin
            o_done_ok      <= 1'b1;
            o_granted_node <= 9'(r_node);
            o_block_x      <= 12'(r_x);
            o_block_y      <= 12'(r_y);
            o_block_size   <= 13'(size);
            o_view_x       <= 12'(32'(r_x) + 32'(inset));
            o_view_y       <= 12'(32'(r_y) + 32'(inset));
            o_view_size    <= 13'(vsize);
        end
    end

endmodule

@@ rtl/quadtree_buddy_allocator.sv @@
// channel   dir  handshake                    payload
// request   in   i_req_valid / o_req_ready    i_opcode, i_requested_resolution,
//                                             i_release_valid, i_release_node
// result    out  o_rsp_valid / i_rsp_ready    o_done_ok .. o_view_size
// config    in   i_cfg_we                     i_cfg_index, i_cfg_wdata
//
// one request at a time; node states live in a TREE_NODES x 2 memory with a
// registered read, so each node probe is a read followed by an evaluation of
// the registered state; a free merges upward from the released node, and an
// allocate walks the tree depth-first
// after reset a clearing pass over all TREE_NODES nodes runs before o_req_ready
// a clear request runs the same clearing pass
// a result holds in its output register until i_rsp_ready takes it
module quadtree_buddy_allocator
    import qtba_pkg::*;
#(
    parameter int ATLAS_SIZE_LOG2 = ATLAS_SIZE_LOG2_DEF,
    parameter int LEAF_SIZE_LOG2  = LEAF_SIZE_LOG2_DEF,
    parameter int TREE_NODES      = TREE_NODES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_wdata,
    // request channel
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_requested_resolution,
    input  logic        i_release_valid,
    input  logic [8:0]  i_release_node,
    // result channel
    output logic        o_rsp_valid,
    input  logic        i_rsp_ready,
    output logic        o_done_ok,
    output logic [8:0]  o_granted_node,
    output logic [11:0] o_block_x,
    output logic [11:0] o_block_y,
    output logic [12:0] o_block_size,
    output logic [11:0] o_view_x,
    output logic [11:0] o_view_y,
    output logic [12:0] o_view_size
);

    // command and status between sequencer and tree datapath
    t_cmd    cmd;
    t_status st;

    // sequencer: depth-first walk, upward merge and clearing pass
    qtba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    // node memory, walk position, config registers and result register
    qtba_dp #(
        .ATLAS_SIZE_LOG2 (ATLAS_SIZE_LOG2),
        .LEAF_SIZE_LOG2  (LEAF_SIZE_LOG2),
        .TREE_NODES      (TREE_NODES)
    ) u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_wdata            (i_cfg_wdata),
        .i_opcode               (i_opcode),
        .i_requested_resolution (i_requested_resolution),
        .i_release_valid        (i_release_valid),
        .i_release_node         (i_release_node),
        .i_cmd                  (cmd),
        .o_st                   (st),
        .o_done_ok              (o_done_ok),
        .o_granted_node         (o_granted_node),
        .o_block_x              (o_block_x),
        .o_block_y              (o_block_y),
        .o_block_size           (o_block_size),
        .o_view_x               (o_view_x),
        .o_view_y               (o_view_y),
        .o_view_size            (o_view_size)
    );

endmodule
